FILE: src/slps_pkg.sv
// slps_pkg: shared types and constants for the skip list pair seek block.
// No dependencies; imported by skip_list_pair_seek, slps_store and slps_seq.
package slps_pkg;

    localparam int ENTRY_DEPTH_DEF = 128;

    localparam int WORD_W = 32;
    localparam int PASS_W = 17;

    localparam logic signed [PASS_W-1:0] PASS_MAX  = 17'sd65535;
    localparam logic signed [PASS_W-1:0] PASS_INIT = -17'sd1;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_RESTART = 2'd0;
    localparam func_t FUNC_APPEND  = 2'd1;
    localparam func_t FUNC_SEEK    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                     found;
        logic [WORD_W-1:0]        found_key;
        logic [WORD_W-1:0]        prev_key;
        logic [WORD_W-1:0]        prev_value;
        logic [WORD_W-1:0]        value_delta;
        logic signed [PASS_W-1:0] skipped_count;
        logic                     store_full;
    } result_t;

endpackage

FILE: src/skip_list_pair_seek.sv
// Skip list pair seek: one list of (key, value) pairs with forward seek.
// Every item gives one result item. A restart or append item goes from acceptance
// straight to the done state. A seek walks the entries in turn, each through a
// read state (registered read of the entry store) and a step state (add and
// compare), until it finds a key or the list runs out. One item is in work at a
// time; a finished result waits in the output register while the next item is
// accepted. The store needs no clearing after reset. reference_mode is written
// via cfg_wen/cfg_wdata by the user only while idle; the block does not enforce it.
module skip_list_pair_seek
    import slps_pkg::*;
#(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic         cfg_wdata,      // reference_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,        // key_word, value_word, query_key
    input  logic [1:0]   s_tuser,        // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,        // found_key, prev_key, prev_value,
                                         // value_delta, skipped_count, zero pad
    output logic [1:0]   m_tuser         // found, store_full
);

    localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW = $clog2(ENTRY_DEPTH + 1);

    logic              mode_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_key;
    logic [WORD_W-1:0] wr_value;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_key;
    logic [WORD_W-1:0] rd_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wen) begin
            mode_reg <= cfg_wdata;
        end
    end

    slps_seq #(
        .DEPTH (ENTRY_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .reference_mode (mode_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_func        (s_tuser),
        .in_key_word    (s_tdata[31:0]),
        .in_value_word  (s_tdata[63:32]),
        .in_query_key   (s_tdata[95:64]),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_key         (wr_key),
        .wr_value       (wr_value),
        .rd_addr        (rd_addr),
        .rd_key         (rd_key),
        .rd_value       (rd_value)
    );

    slps_store #(
        .DEPTH (ENTRY_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_res_reg.store_full, m_res_reg.found};
    assign m_tdata  = {7'b0,
                       m_res_reg.skipped_count,
                       m_res_reg.value_delta,
                       m_res_reg.prev_value,
                       m_res_reg.prev_key,
                       m_res_reg.found_key};

endmodule

FILE: src/slps_store.sv
// slps_store: entry store holding key words and value words of the list.
// One write port, one registered read port. Depends on slps_pkg.
module slps_store
    import slps_pkg::*;
#(
    parameter int DEPTH = ENTRY_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_key,
    input  logic [WORD_W-1:0] wr_value,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_key,
    output logic [WORD_W-1:0] rd_value
);

    logic [WORD_W-1:0] key_mem   [DEPTH];
    logic [WORD_W-1:0] value_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

FILE: src/slps_seq.sv
// slps_seq: sequencer and shared add/compare step of the seek walk.
// Holds cursor, entry count, running sums and pass count. Depends on slps_pkg.
module slps_seq
    import slps_pkg::*;
#(
    parameter int DEPTH = ENTRY_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              reference_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  func_t             in_func,
    input  logic [WORD_W-1:0] in_key_word,
    input  logic [WORD_W-1:0] in_value_word,
    input  logic [WORD_W-1:0] in_query_key,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [WORD_W-1:0] wr_key,
    output logic [WORD_W-1:0] wr_value,
    output logic [AW-1:0]     rd_addr,
    input  logic [WORD_W-1:0] rd_key,
    input  logic [WORD_W-1:0] rd_value
);

    seq_state_t               state_reg, state_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            cursor_reg;
    logic [WORD_W-1:0]        run_key_reg;
    logic [WORD_W-1:0]        run_value_reg;
    logic signed [PASS_W-1:0] pass_reg;
    logic [WORD_W-1:0]        query_reg;
    result_t                  res_reg;

    logic                     accept;
    logic                     full;
    logic                     entries_left;
    logic [WORD_W-1:0]        step_key;
    logic [WORD_W-1:0]        step_value;
    logic                     hit;

    assign accept       = in_valid && in_ready;
    assign full         = (count_reg == CW'(DEPTH));
    assign entries_left = (cursor_reg < count_reg);
    assign step_key     = reference_mode ? rd_key : rd_key + run_key_reg;
    assign step_value   = run_value_reg + rd_value;
    assign hit          = (step_key >= query_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_func == FUNC_SEEK) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                state_next = entries_left ? ST_STEP : ST_DONE;
            end
            ST_STEP: begin
                state_next = hit ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        wr_en     = accept && (in_func == FUNC_APPEND) && !full;
        wr_addr   = count_reg[AW-1:0];
        wr_key    = in_key_word;
        wr_value  = in_value_word;
        rd_addr   = cursor_reg[AW-1:0];
        res       = res_reg;
        res.skipped_count = pass_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            run_key_reg   <= '0;
            run_value_reg <= '0;
            pass_reg      <= PASS_INIT;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        query_reg             <= in_query_key;
                        res_reg.found         <= 1'b0;
                        res_reg.found_key     <= '0;
                        res_reg.prev_key      <= '0;
                        res_reg.prev_value    <= '0;
                        res_reg.value_delta   <= '0;
                        res_reg.skipped_count <= '0;
                        res_reg.store_full    <= (in_func == FUNC_APPEND) && full;
                        if (in_func == FUNC_RESTART) begin
                            count_reg     <= '0;
                            cursor_reg    <= '0;
                            run_key_reg   <= '0;
                            run_value_reg <= '0;
                            pass_reg      <= PASS_INIT;
                        end
                        if (wr_en) begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                ST_READ: begin
                    if (pass_reg != PASS_MAX) begin
                        pass_reg <= pass_reg + 17'sd1;
                    end
                end
                ST_STEP: begin
                    run_key_reg   <= step_key;
                    run_value_reg <= step_value;
                    cursor_reg    <= cursor_reg + CW'(1);
                    if (hit) begin
                        res_reg.found       <= 1'b1;
                        res_reg.found_key   <= step_key;
                        res_reg.prev_key    <= run_key_reg;
                        res_reg.prev_value  <= run_value_reg;
                        res_reg.value_delta <= rd_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/slps_checker.sv
// slps_checker: port-level checks of the skip list pair seek block.
// Bound to skip_list_pair_seek below; uses its ports only.
module slps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_wen,
    input logic         cfg_wdata,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [95:0]  s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_found_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("found and store_full both set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[127:0] == 128'd0)
        else $error("key or value fields set without a found key");

    a_pass_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[144] || m_tdata[144:128] == 17'h1ffff)
        else $error("skipped_count below minus one");

endmodule

bind skip_list_pair_seek slps_checker u_slps_checker (.*);
